FILE: hw/rtl/scfp_pkg.sv
// Shared types, constants and arithmetic helpers for the serial command frame parser.
// Used by scfp_frame_step and serial_command_frame_parser; no other dependencies.
`timescale 1ns / 1ps

package scfp_pkg;

  // Body buffer depth and the width of the body position counter
  localparam int BUF_DEPTH = 32;
  localparam int CNT_W     = $clog2(BUF_DEPTH);
  localparam logic [CNT_W-1:0] BODY_MAX = CNT_W'(BUF_DEPTH - 1);

  // Input word kinds
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_RESET = 1'b1;

  // Frame delimiters and other characters
  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h23;  // '#'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Command characters
  localparam logic [7:0] CMD_FWD   = 8'h46;  // 'F'
  localparam logic [7:0] CMD_BACK  = 8'h42;  // 'B'
  localparam logic [7:0] CMD_LEFT  = 8'h4C;  // 'L'
  localparam logic [7:0] CMD_RIGHT = 8'h52;  // 'R'
  localparam logic [7:0] CMD_STOP  = 8'h53;  // 'S'
  localparam logic [7:0] CMD_VEL   = 8'h56;  // 'V'

  // Default targets in hundredths
  localparam logic signed [15:0] DEF_SPEED = 16'sd30;
  localparam logic signed [15:0] DEF_TURN  = 16'sd50;
  localparam logic signed [20:0] ARG_LIMIT = 21'sd32767;

  typedef enum logic [2:0] {
    MODE_NONE  = 3'd0,
    MODE_FWD   = 3'd1,
    MODE_BACK  = 3'd2,
    MODE_LEFT  = 3'd3,
    MODE_RIGHT = 3'd4,
    MODE_STOP  = 3'd5,
    MODE_VEL   = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_A_LEAD  = 3'd1,
    PH_A_SIGN  = 3'd2,
    PH_A_DIGIT = 3'd3,
    PH_B_LEAD  = 3'd4,
    PH_B_SIGN  = 3'd5,
    PH_B_DIGIT = 3'd6
  } phase_t;

  typedef struct packed {
    logic                    in_frame;
    logic [CNT_W-1:0]        body_count;
    logic [7:0]              first_char;
    logic                    text_ended;
    phase_t                  phase;
    logic                    arg_negative;
    logic signed [15:0]      first_accum;
    logic signed [15:0]      second_accum;
    logic [1:0]              args_found;
  } frame_state_t;

  localparam frame_state_t FRAME_CLEAR = '{
    in_frame:     1'b0,
    body_count:   '0,
    first_char:   8'h00,
    text_ended:   1'b0,
    phase:        PH_IDLE,
    arg_negative: 1'b0,
    first_accum:  16'sd0,
    second_accum: 16'sd0,
    args_found:   2'd0
  };

  // Shift in one decimal digit and saturate to +-32767
  function automatic logic signed [15:0] acc_digit(input logic signed [15:0] acc,
                                                   input logic [3:0] d,
                                                   input logic neg);
    logic signed [20:0] ext;
    logic signed [20:0] prod;
    logic signed [20:0] dig;
    logic signed [20:0] v;
    ext  = $signed({{5{acc[15]}}, acc});
    prod = ext * 21'sd10;
    dig  = $signed({17'd0, d});
    if (neg) begin
      v = prod - dig;
      if (v < -ARG_LIMIT) v = -ARG_LIMIT;
    end else begin
      v = prod + dig;
      if (v > ARG_LIMIT) v = ARG_LIMIT;
    end
    return v[15:0];
  endfunction

endpackage

FILE: hw/rtl/scfp_frame_step.sv
// Next-state logic of the frame and argument parser for one input word.
// Depends on scfp_pkg for the state struct, phase codes and digit helper.
`timescale 1ns / 1ps

module scfp_frame_step (
  input  scfp_pkg::frame_state_t cur,
  input  logic                   opcode,
  input  logic [7:0]             rx_data,
  output scfp_pkg::frame_state_t nxt,
  output logic                   frame_done
);

  logic       is_digit;
  logic       is_ws;
  logic       is_b;
  logic       ph_lead;
  logic       ph_sign;
  logic       ph_digit;
  logic       neg_eff;
  logic [3:0] dval;
  logic signed [15:0] acc_cur;
  logic signed [15:0] acc_new;
  scfp_pkg::frame_state_t body;

  // Classify the byte
  assign is_digit = (rx_data >= scfp_pkg::CH_ZERO) && (rx_data <= scfp_pkg::CH_NINE);
  assign is_ws    = (rx_data == scfp_pkg::CH_SPACE) ||
                    ((rx_data >= scfp_pkg::CH_TAB) && (rx_data <= scfp_pkg::CH_CR));
  assign dval     = rx_data[3:0];

  // Decode the argument phase
  assign is_b     = (cur.phase == scfp_pkg::PH_B_LEAD) || (cur.phase == scfp_pkg::PH_B_SIGN) ||
                    (cur.phase == scfp_pkg::PH_B_DIGIT);
  assign ph_lead  = (cur.phase == scfp_pkg::PH_A_LEAD) || (cur.phase == scfp_pkg::PH_B_LEAD);
  assign ph_sign  = (cur.phase == scfp_pkg::PH_A_SIGN) || (cur.phase == scfp_pkg::PH_B_SIGN);
  assign ph_digit = (cur.phase == scfp_pkg::PH_A_DIGIT) || (cur.phase == scfp_pkg::PH_B_DIGIT);
  assign acc_cur  = is_b ? cur.second_accum : cur.first_accum;
  assign neg_eff  = ph_lead ? 1'b0 : cur.arg_negative;
  assign acc_new  = scfp_pkg::acc_digit(ph_digit ? acc_cur : 16'sd0, dval,
                                        ph_digit ? cur.arg_negative : neg_eff);

  // Advance the body by one byte
  always_comb begin
    body = cur;
    body.body_count = cur.body_count + 1'b1;
    if (!cur.text_ended) begin
      if (rx_data == scfp_pkg::CH_NUL) begin
        body.text_ended = 1'b1;
        body.phase      = scfp_pkg::PH_IDLE;
      end else if (cur.body_count == '0) begin
        body.first_char = rx_data;
      end else if (cur.body_count == scfp_pkg::CNT_W'(1)) begin
        body.phase = (rx_data == scfp_pkg::CH_COMMA) ? scfp_pkg::PH_A_LEAD
                                                      : scfp_pkg::PH_IDLE;
      end else if (ph_lead && is_ws) begin
        // skip leading whitespace
      end else if (ph_lead && ((rx_data == scfp_pkg::CH_PLUS) ||
                               (rx_data == scfp_pkg::CH_MINUS))) begin
        body.arg_negative = (rx_data == scfp_pkg::CH_MINUS);
        body.phase        = is_b ? scfp_pkg::PH_B_SIGN : scfp_pkg::PH_A_SIGN;
      end else if (ph_lead || ph_sign) begin
        if (is_digit) begin
          body.arg_negative = neg_eff;
          body.phase        = is_b ? scfp_pkg::PH_B_DIGIT : scfp_pkg::PH_A_DIGIT;
          body.args_found   = is_b ? 2'd2 : 2'd1;
          if (is_b) body.second_accum = acc_new;
          else      body.first_accum  = acc_new;
        end else begin
          body.phase = scfp_pkg::PH_IDLE;
        end
      end else if (ph_digit) begin
        if (is_digit) begin
          if (is_b) body.second_accum = acc_new;
          else      body.first_accum  = acc_new;
        end else if ((rx_data == scfp_pkg::CH_COMMA) && !is_b) begin
          body.phase = scfp_pkg::PH_B_LEAD;
        end else begin
          body.phase = scfp_pkg::PH_IDLE;
        end
      end
    end
  end

  // Select the frame-level action
  always_comb begin
    nxt        = cur;
    frame_done = 1'b0;
    if (opcode == scfp_pkg::OP_RESET) begin
      nxt = scfp_pkg::FRAME_CLEAR;
    end else if (!cur.in_frame) begin
      if (rx_data == scfp_pkg::CH_START) begin
        nxt          = scfp_pkg::FRAME_CLEAR;
        nxt.in_frame = 1'b1;
      end
    end else if (rx_data == scfp_pkg::CH_END) begin
      frame_done = (cur.body_count != '0) && (cur.first_char != scfp_pkg::CH_NUL);
      nxt        = scfp_pkg::FRAME_CLEAR;
    end else if (rx_data == scfp_pkg::CH_START) begin
      nxt          = scfp_pkg::FRAME_CLEAR;
      nxt.in_frame = 1'b1;
    end else if (cur.body_count < scfp_pkg::BODY_MAX) begin
      nxt = body;
    end else begin
      nxt = scfp_pkg::FRAME_CLEAR;
    end
  end

endmodule

FILE: hw/rtl/serial_command_frame_parser.sv
// A result is registered into the output register when the closing '#' word is accepted.
// Throughput: one word per cycle while in_stall is low; the combinational byte parse and digit accumulate
// between the frame state registers and the output register set the rate.
// Input stalls only while a result waits in the output register and the sink stalls.
// Reset (rst, synchronous, active high) clears frame state, held controls, output valid.
// Depends on scfp_pkg and scfp_frame_step.
`timescale 1ns / 1ps

module serial_command_frame_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [7:0]         rx_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         ack_char,
  output logic signed [15:0] ack_first,
  output logic signed [15:0] ack_second,
  output logic [2:0]         drive_mode,
  output logic signed [15:0] speed_centi,
  output logic signed [15:0] turn_centi,
  output logic               control_updated
);

  scfp_pkg::frame_state_t state;
  scfp_pkg::frame_state_t state_next;
  logic                   frame_done;
  logic                   accept;

  scfp_pkg::mode_t        held_mode;
  logic signed [15:0]     held_speed;
  logic signed [15:0]     held_turn;
  scfp_pkg::mode_t        held_mode_next;
  logic signed [15:0]     held_speed_next;
  logic signed [15:0]     held_turn_next;
  logic                   upd;
  logic                   has1;
  logic signed [15:0]     a1;
  logic signed [15:0]     a2;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  scfp_frame_step u_step (
    .cur        (state),
    .opcode     (opcode),
    .rx_data    (rx_data),
    .nxt        (state_next),
    .frame_done (frame_done)
  );

  // Decode the finished command into new held values
  assign has1 = (state.args_found != 2'd0);
  assign a1   = has1 ? state.first_accum : 16'sd0;
  assign a2   = (state.args_found == 2'd2) ? state.second_accum : 16'sd0;

  always_comb begin
    held_mode_next  = held_mode;
    held_speed_next = held_speed;
    held_turn_next  = held_turn;
    upd             = 1'b1;
    case (state.first_char)
      scfp_pkg::CMD_FWD: begin
        held_mode_next  = scfp_pkg::MODE_FWD;
        held_speed_next = has1 ? a1 : scfp_pkg::DEF_SPEED;
        held_turn_next  = 16'sd0;
      end
      scfp_pkg::CMD_BACK: begin
        held_mode_next  = scfp_pkg::MODE_BACK;
        held_speed_next = has1 ? -a1 : -scfp_pkg::DEF_SPEED;
        held_turn_next  = 16'sd0;
      end
      scfp_pkg::CMD_LEFT: begin
        held_mode_next  = scfp_pkg::MODE_LEFT;
        held_speed_next = 16'sd0;
        held_turn_next  = has1 ? -a1 : -scfp_pkg::DEF_TURN;
      end
      scfp_pkg::CMD_RIGHT: begin
        held_mode_next  = scfp_pkg::MODE_RIGHT;
        held_speed_next = 16'sd0;
        held_turn_next  = has1 ? a1 : scfp_pkg::DEF_TURN;
      end
      scfp_pkg::CMD_STOP: begin
        held_mode_next  = scfp_pkg::MODE_STOP;
        held_speed_next = 16'sd0;
        held_turn_next  = 16'sd0;
      end
      scfp_pkg::CMD_VEL: begin
        held_mode_next  = scfp_pkg::MODE_VEL;
        held_speed_next = a1;
        held_turn_next  = a2;
      end
      default: begin
        upd = 1'b0;
      end
    endcase
  end

  // Hold frame state and control values, advance on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= scfp_pkg::FRAME_CLEAR;
      held_mode  <= scfp_pkg::MODE_NONE;
      held_speed <= 16'sd0;
      held_turn  <= 16'sd0;
    end else if (accept) begin
      state <= state_next;
      if (frame_done) begin
        held_mode  <= held_mode_next;
        held_speed <= held_speed_next;
        held_turn  <= held_turn_next;
      end
    end
  end

  // Output register: load a result word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && frame_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame_done) begin
      ack_char        <= state.first_char;
      ack_first       <= a1;
      ack_second      <= a2;
      drive_mode      <= held_mode_next;
      speed_centi     <= held_speed_next;
      turn_centi      <= held_turn_next;
      control_updated <= upd;
    end
  end

endmodule
